// ----- rtl/bsa_pkg.sv -----
package bsa_pkg;

  // fixed field widths of the stream and register ports
  localparam int CMD_W    = 2;
  localparam int PAGE_W   = 3;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 16;
  localparam int CFG_W    = 7;
  localparam int ADDR_W   = 3;
  localparam int APB_W    = 32;

  // default geometry
  localparam int DEF_PAGE_COUNT = 8;
  localparam int DEF_MAX_SLOTS  = 64;

  // register map, index taken from the word address
  localparam logic REG_SLOTS_PER_PAGE = 1'b0;
  localparam logic [CFG_W-1:0] SPP_RESET = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_SHRINK = 2'd2
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_code_t;

  // which result the datapath captures
  typedef enum logic [2:0] {
    RES_GRANT,
    RES_ACT,
    RES_SHRINK,
    RES_OK,
    RES_FULL,
    RES_IGN
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     load_item;
    logic     ptr_clear;
    logic     ptr_inc;
    logic     ptr_top;
    logic     ptr_dec;
    logic     rd_ptr;
    logic     rd_item;
    logic     wr_alloc;
    logic     wr_activate;
    logic     wr_free;
    logic     deactivate;
    logic     note_inactive;
    logic     res_load;
    res_sel_t res_sel;
    logic     out_load;
  } bsa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             cur_active;
    logic             p_last;
    logic             p_zero;
    logic             slot_found;
    logic             word_zero;
    logic             multi_active;
    logic             free_ok;
    logic             inact_found;
    logic             out_free;
  } bsa_stat_t;

endpackage

// ----- rtl/bsa_ctrl.sv -----
module bsa_ctrl
  import bsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bsa_stat_t stat,
  output bsa_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_DISPATCH  = 9'b000000010,
    S_ALLOC_RD  = 9'b000000100,
    S_ALLOC_CHK = 9'b000001000,
    S_ALLOC_END = 9'b000010000,
    S_FREE_WR   = 9'b000100000,
    S_SHR_RD    = 9'b001000000,
    S_SHR_CHK   = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_sel = RES_IGN;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.cmd)
          CMD_ALLOC: begin
            cmd.ptr_clear = 1'b1;
            state_next    = S_ALLOC_RD;
          end
          CMD_FREE: begin
            if (stat.free_ok) begin
              cmd.rd_item = 1'b1;
              state_next  = S_FREE_WR;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_IGN;
              state_next   = S_DONE;
            end
          end
          CMD_SHRINK: begin
            if (stat.multi_active) begin
              cmd.ptr_top = 1'b1;
              state_next  = S_SHR_RD;
            end else begin
              cmd.res_load = 1'b1;
              cmd.res_sel  = RES_IGN;
              state_next   = S_DONE;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_IGN;
            state_next   = S_DONE;
          end
        endcase
      end
      S_ALLOC_RD: begin
        if (stat.cur_active) begin
          cmd.rd_ptr = 1'b1;
          state_next = S_ALLOC_CHK;
        end else begin
          cmd.note_inactive = 1'b1;
          if (stat.p_last) begin
            state_next = S_ALLOC_END;
          end else begin
            cmd.ptr_inc = 1'b1;
          end
        end
      end
      S_ALLOC_CHK: begin
        if (stat.slot_found) begin
          cmd.wr_alloc = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_GRANT;
          state_next   = S_DONE;
        end else if (stat.p_last) begin
          state_next = S_ALLOC_END;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_ALLOC_RD;
        end
      end
      S_ALLOC_END: begin
        cmd.res_load = 1'b1;
        if (stat.inact_found) begin
          cmd.wr_activate = 1'b1;
          cmd.res_sel     = RES_ACT;
        end else begin
          cmd.res_sel = RES_FULL;
        end
        state_next = S_DONE;
      end
      S_FREE_WR: begin
        cmd.wr_free  = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_OK;
        state_next   = S_DONE;
      end
      S_SHR_RD: begin
        if (stat.cur_active) begin
          cmd.rd_ptr = 1'b1;
          state_next = S_SHR_CHK;
        end else if (stat.p_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_IGN;
          state_next   = S_DONE;
        end else begin
          cmd.ptr_dec = 1'b1;
        end
      end
      S_SHR_CHK: begin
        if (stat.word_zero) begin
          cmd.deactivate = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_sel    = RES_SHRINK;
          state_next     = S_DONE;
        end else if (stat.p_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_IGN;
          state_next   = S_DONE;
        end else begin
          cmd.ptr_dec = 1'b1;
          state_next  = S_SHR_RD;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/bsa_dpath.sv -----
module bsa_dpath
  import bsa_pkg::*;
#(
  parameter int PAGE_COUNT = DEF_PAGE_COUNT,
  parameter int MAX_SLOTS  = DEF_MAX_SLOTS
) (
  input  logic                clk,
  input  logic                rst,
  input  bsa_cmd_t            cmd,
  output bsa_stat_t           stat,
  input  logic [CFG_W-1:0]    limit,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [PAGE_W-1:0]   in_page,
  input  logic [SLOT_W-1:0]   in_slot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [PAGE_W-1:0]   out_page,
  output logic [SLOT_W-1:0]   out_slot
);

  localparam int PW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int SLW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  // occupancy bitmaps, one word per page
  logic [MAX_SLOTS-1:0] occ_mem [PAGE_COUNT];
  logic [PAGE_COUNT-1:0] page_init;
  logic [PAGE_COUNT-1:0] page_active;

  logic [CMD_W-1:0]  cmd_q;
  logic [PAGE_W-1:0] pg_q;
  logic [SLOT_W-1:0] sl_q;
  logic [PW-1:0]     ptr;
  logic [PW-1:0]     inact_page;
  logic              inact_found;
  logic [MAX_SLOTS-1:0] rd_q;
  logic              rd_init;

  logic [STATUS_W-1:0] res_status;
  logic [PW-1:0]       res_page;
  logic [SLW-1:0]      res_slot;

  logic [PW-1:0]        pg_idx;
  logic [SLW-1:0]       sl_idx;
  logic [PW-1:0]        rd_addr;
  logic [MAX_SLOTS-1:0] rd_word;
  logic [MAX_SLOTS-1:0] below;
  logic [MAX_SLOTS-1:0] zeros;
  logic [MAX_SLOTS-1:0] low_oh;
  logic [SLW-1:0]       slot_idx;
  logic                 wr_en;
  logic [PW-1:0]        wr_addr;
  logic [MAX_SLOTS-1:0] wr_data;
  logic [PAGE_COUNT-1:0] act_less;
  logic [PW+2:0]        page_ext;
  logic [SLW+5:0]       slot_ext;

  assign pg_idx  = PW'(pg_q);
  assign sl_idx  = SLW'(sl_q);
  assign rd_addr = cmd.rd_item ? pg_idx : ptr;
  assign rd_word = rd_init ? rd_q : '0;

  // lowest free slot below the limit
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      below[i] = (CFG_W'(i) < limit);
    end
    zeros  = ~(rd_word | ~below);
    low_oh = zeros & (~zeros + MAX_SLOTS'(1));
    slot_idx = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (low_oh[i]) begin
        slot_idx = slot_idx | SLW'(i);
      end
    end
  end

  // memory write selection
  always_comb begin
    wr_en   = cmd.wr_alloc | cmd.wr_activate | cmd.wr_free;
    wr_addr = ptr;
    wr_data = rd_word | (MAX_SLOTS'(1) << slot_idx);
    if (cmd.wr_activate) begin
      wr_addr = inact_page;
      wr_data = MAX_SLOTS'(1);
    end else if (cmd.wr_free) begin
      wr_addr = pg_idx;
      wr_data = rd_word & ~(MAX_SLOTS'(1) << sl_idx);
    end
  end

  // bitmap memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      occ_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_ptr || cmd.rd_item) begin
      rd_q <= occ_mem[rd_addr];
    end
  end

  // page state and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      page_init   <= '0;
      page_active <= PAGE_COUNT'(1);
      inact_found <= 1'b0;
      out_valid   <= 1'b0;
      ptr         <= '0;
      rd_init     <= 1'b0;
    end else begin
      if (cmd.rd_ptr || cmd.rd_item) begin
        rd_init <= page_init[rd_addr];
      end
      if (wr_en) begin
        page_init[wr_addr] <= 1'b1;
      end
      if (cmd.wr_activate) begin
        page_active[inact_page] <= 1'b1;
      end
      if (cmd.deactivate) begin
        page_active[ptr] <= 1'b0;
      end
      if (cmd.load_item) begin
        inact_found <= 1'b0;
      end else if (cmd.note_inactive && !inact_found) begin
        inact_found <= 1'b1;
      end
      if (cmd.ptr_clear) begin
        ptr <= '0;
      end else if (cmd.ptr_top) begin
        ptr <= PW'(PAGE_COUNT - 1);
      end else if (cmd.ptr_inc) begin
        ptr <= ptr + PW'(1);
      end else if (cmd.ptr_dec) begin
        ptr <= ptr - PW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item, scan record and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_q <= in_command;
      pg_q  <= in_page;
      sl_q  <= in_slot;
    end
    if (cmd.note_inactive && !inact_found) begin
      inact_page <= ptr;
    end
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_GRANT: begin
          res_status <= ST_DONE;
          res_page   <= ptr;
          res_slot   <= slot_idx;
        end
        RES_ACT: begin
          res_status <= ST_DONE;
          res_page   <= inact_page;
          res_slot   <= '0;
        end
        RES_SHRINK: begin
          res_status <= ST_DONE;
          res_page   <= ptr;
          res_slot   <= '0;
        end
        RES_OK: begin
          res_status <= ST_DONE;
          res_page   <= '0;
          res_slot   <= '0;
        end
        RES_FULL: begin
          res_status <= ST_FULL;
          res_page   <= '0;
          res_slot   <= '0;
        end
        default: begin
          res_status <= ST_IGNORED;
          res_page   <= '0;
          res_slot   <= '0;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_page   <= page_ext[PAGE_W-1:0];
      out_slot   <= slot_ext[SLOT_W-1:0];
    end
  end

  assign page_ext = (PW + 3)'(res_page);
  assign slot_ext = (SLW + 6)'(res_slot);

  // status toward the controller
  assign act_less = page_active - PAGE_COUNT'(1);

  always_comb begin
    stat.cmd          = cmd_q;
    stat.cur_active   = page_active[ptr];
    stat.p_last       = (ptr == PW'(PAGE_COUNT - 1));
    stat.p_zero       = (ptr == '0);
    stat.slot_found   = |zeros;
    stat.word_zero    = (rd_word == '0);
    stat.multi_active = |(page_active & act_less);
    stat.free_ok      = (32'(pg_q) < 32'(PAGE_COUNT)) && page_active[pg_idx]
                        && ({1'b0, sl_q} < limit);
    stat.inact_found  = inact_found;
    stat.out_free     = !out_valid || out_ready;
  end

endmodule

// ----- rtl/bitmap_slot_allocator_unit.sv -----
// flow: an ignored free, an unknown command or a shrink with one page active loads the result
//   straight from dispatch; free reads the page word, then writes it back; allocate scans the
//   pages upward, reading each active one and passing inactive ones, then activates a page or
//   reports full; shrink scans down from the top page; the result then goes to the output
// requests: one in flight, the next is taken once the result is loaded into the output register
// reset: synchronous; page 0 active, all slots free, slots per page 64, no clearing pass
module bitmap_slot_allocator_unit
  import bsa_pkg::*;
#(
  parameter int PAGE_COUNT = DEF_PAGE_COUNT,
  parameter int MAX_SLOTS  = DEF_MAX_SLOTS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [DATA_W-1:0]   s_tdata,   // page_index[2:0], slot_index[8:3], zero pad
  input  logic [CMD_W-1:0]    s_tuser,   // command[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [DATA_W-1:0]   m_tdata,   // out_page[2:0], out_slot[8:3], zero pad
  output logic [STATUS_W-1:0] m_tuser,   // status[1:0]
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [APB_W-1:0]    pwdata,
  output logic [APB_W-1:0]    prdata,
  output logic                pready
);

  logic [CFG_W-1:0]    slots_per_page;
  logic [CFG_W-1:0]    limit;
  logic                reg_write;
  logic                reg_sel;
  bsa_cmd_t            cmd;
  bsa_stat_t           stat;
  logic [PAGE_W-1:0]   out_page;
  logic [SLOT_W-1:0]   out_slot;

  // register port
  assign pready    = 1'b1;
  assign reg_sel   = paddr[ADDR_W-1];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_per_page <= SPP_RESET;
    end else if (reg_write && reg_sel == REG_SLOTS_PER_PAGE) begin
      slots_per_page <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (reg_sel == REG_SLOTS_PER_PAGE) ? APB_W'(slots_per_page) : '0;

  // effective slots per page, clamped to one .. MAX_SLOTS
  always_comb begin
    if (slots_per_page == '0) begin
      limit = CFG_W'(1);
    end else if (slots_per_page > CFG_W'(MAX_SLOTS)) begin
      limit = CFG_W'(MAX_SLOTS);
    end else begin
      limit = slots_per_page;
    end
  end

  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bsa_dpath #(
    .PAGE_COUNT (PAGE_COUNT),
    .MAX_SLOTS  (MAX_SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .limit      (limit),
    .in_command (s_tuser),
    .in_page    (s_tdata[PAGE_W-1:0]),
    .in_slot    (s_tdata[PAGE_W+SLOT_W-1:PAGE_W]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_page   (out_page),
    .out_slot   (out_slot)
  );

  // output packing
  assign m_tdata = {{(DATA_W - PAGE_W - SLOT_W){1'b0}}, out_slot, out_page};

endmodule
